@@ sv/i2cbdm_pkg.sv @@
// Shared types and codes for the I2C byte-data master.
`default_nettype none

package i2cbdm_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] SDA_LOW  = 2'd0;
  localparam logic [1:0] SDA_HIGH = 2'd1;
  localparam logic [1:0] SDA_REL  = 2'd2;

  localparam logic [1:0] BS_ADDR = 2'd0;
  localparam logic [1:0] BS_CMD  = 2'd1;
  localparam logic [1:0] BS_DATA = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] target_addr;
    logic [7:0] command;
    logic [7:0] write_value;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic [1:0] sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
    logic [7:0] result_data;
  } res_t;

endpackage

`default_nettype wire

@@ sv/i2c_byte_data_master_top.sv @@
// Top level of the I2C byte-data master: input and result registers around the sequencer.
//
//   channel | direction | tdata                                     | tuser
//   in_     | slave     | target_addr, command, write_value, sda_in | mode
//   out_    | master    | scl, sda_drive, busy, done, nack, data    | -
//
// One input word gives one result word; a word can be taken every cycle while the result is not stalled.
// An accepted word is held in the input register and is stepped through the
// sequencer into the result register when that register is empty or its word
// is being taken, and its result is then offered from there.
// Reset leaves both registers empty and the sequencer idle with the clock
// high and the data line released.
// A stalled result holds; one further input word is still taken into the
// input register, after which in_tready falls until the result moves on.
`default_nettype none

module i2c_byte_data_master_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [6:0] target_addr, [14:7] command, [22:15] write_value, [23] sda_in
  input  wire logic [23:0] in_tdata,
  // [1:0] mode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] scl_out, [2:1] sda_drive, [3] busy_res, [4] done_res, [5] nack_error,
  // [13:6] result_data, [15:14] zero
  output logic [15:0]      out_tdata
);

  i2cbdm_pkg::req_t req_r;
  i2cbdm_pkg::res_t res;
  i2cbdm_pkg::res_t res_r;
  logic             in_vld_r;
  logic             out_vld_r;
  logic             adv;
  logic             step;

  assign adv       = !out_vld_r || out_tready;
  assign step      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.mode        <= in_tuser;
      req_r.target_addr <= in_tdata[6:0];
      req_r.command     <= in_tdata[14:7];
      req_r.write_value <= in_tdata[22:15];
      req_r.sda_in      <= in_tdata[23];
    end
  end

  i2cbdm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (req_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res_r.result_data, res_r.nack_error, res_r.done_res,
                       res_r.busy_res, res_r.sda_drive, res_r.scl_out};

endmodule

`default_nettype wire

@@ sv/i2cbdm_seq.sv @@
// Pin action sequencer: transaction state and the result of one step.
`default_nettype none

module i2cbdm_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire i2cbdm_pkg::req_t req,
  output i2cbdm_pkg::res_t      res
);

  typedef enum logic [25:0] {
    PH_IDLE      = 26'h0000001,
    PH_S_CLK0    = 26'h0000002,
    PH_S_DAT1    = 26'h0000004,
    PH_S_CLK1    = 26'h0000008,
    PH_S_DAT0    = 26'h0000010,
    PH_O_CLK0    = 26'h0000020,
    PH_O_DATA    = 26'h0000040,
    PH_O_HI      = 26'h0000080,
    PH_O_LO      = 26'h0000100,
    PH_O_REL     = 26'h0000200,
    PH_O_ACKHI   = 26'h0000400,
    PH_O_ACKSMP  = 26'h0000800,
    PH_O_ACKLO   = 26'h0001000,
    PH_O_ACKFAIL = 26'h0002000,
    PH_I_CLK0    = 26'h0004000,
    PH_I_REL     = 26'h0008000,
    PH_I_HI      = 26'h0010000,
    PH_I_SMP     = 26'h0020000,
    PH_I_LO      = 26'h0040000,
    PH_I_ACKHI   = 26'h0080000,
    PH_I_ACKLO   = 26'h0100000,
    PH_I_REL2    = 26'h0200000,
    PH_P_CLK0    = 26'h0400000,
    PH_P_DAT0    = 26'h0800000,
    PH_P_CLK1    = 26'h1000000,
    PH_P_DAT1    = 26'h2000000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       is_read_r, is_read_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] val_r, val_nxt;
  logic       scl_r, scl_nxt;
  logic [1:0] sda_r, sda_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic [3:0] cnt_inc;
  logic       done;
  logic       nack;
  logic [7:0] data;

  assign cnt_inc = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    is_read_nxt = is_read_r;
    addr_nxt    = addr_r;
    cmd_nxt     = cmd_r;
    val_nxt     = val_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    stage_nxt   = stage_r;
    done        = 1'b0;
    nack        = 1'b0;
    data        = 8'd0;
    if (phase_r == PH_IDLE) begin
      if (req.mode == i2cbdm_pkg::MODE_READ || req.mode == i2cbdm_pkg::MODE_WRITE) begin
        is_read_nxt = (req.mode == i2cbdm_pkg::MODE_READ);
        addr_nxt    = req.target_addr;
        cmd_nxt     = req.command;
        val_nxt     = req.write_value;
        stage_nxt   = i2cbdm_pkg::BS_ADDR;
        bit_cnt_nxt = 4'd0;
        phase_nxt   = PH_S_CLK0;
      end
    end else if (req.mode == i2cbdm_pkg::MODE_TICK) begin
      unique case (phase_r)
        PH_S_CLK0: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_S_DAT1;
        end
        PH_S_DAT1: begin
          sda_nxt   = i2cbdm_pkg::SDA_HIGH;
          phase_nxt = PH_S_CLK1;
        end
        PH_S_CLK1: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_S_DAT0;
        end
        PH_S_DAT0: begin
          sda_nxt     = i2cbdm_pkg::SDA_LOW;
          shift_nxt   = {addr_r, (stage_r == i2cbdm_pkg::BS_DATA)};
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_O_CLK0;
        end
        PH_O_CLK0: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_O_DATA;
        end
        PH_O_DATA: begin
          sda_nxt   = shift_r[7] ? i2cbdm_pkg::SDA_HIGH : i2cbdm_pkg::SDA_LOW;
          phase_nxt = PH_O_HI;
        end
        PH_O_HI: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_O_LO;
        end
        PH_O_LO: begin
          scl_nxt     = 1'b0;
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = cnt_inc;
          phase_nxt   = (cnt_inc >= 4'd8) ? PH_O_REL : PH_O_DATA;
        end
        PH_O_REL: begin
          sda_nxt   = i2cbdm_pkg::SDA_REL;
          phase_nxt = PH_O_ACKHI;
        end
        PH_O_ACKHI: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_O_ACKSMP;
        end
        PH_O_ACKSMP: begin
          phase_nxt = req.sda_in ? PH_O_ACKFAIL : PH_O_ACKLO;
        end
        PH_O_ACKFAIL: begin
          scl_nxt   = 1'b0;
          done      = 1'b1;
          nack      = 1'b1;
          phase_nxt = PH_IDLE;
        end
        PH_O_ACKLO: begin
          scl_nxt     = 1'b0;
          bit_cnt_nxt = 4'd0;
          if (stage_r == i2cbdm_pkg::BS_ADDR) begin
            stage_nxt = i2cbdm_pkg::BS_CMD;
            shift_nxt = cmd_r;
            phase_nxt = PH_O_CLK0;
          end else if (stage_r == i2cbdm_pkg::BS_CMD) begin
            stage_nxt = i2cbdm_pkg::BS_DATA;
            if (is_read_r) begin
              phase_nxt = PH_S_CLK0;
            end else begin
              shift_nxt = val_r;
              phase_nxt = PH_O_CLK0;
            end
          end else begin
            shift_nxt = 8'd0;
            phase_nxt = is_read_r ? PH_I_CLK0 : PH_P_CLK0;
          end
        end
        PH_I_CLK0: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_I_REL;
        end
        PH_I_REL: begin
          sda_nxt   = i2cbdm_pkg::SDA_REL;
          phase_nxt = PH_I_HI;
        end
        PH_I_HI: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_I_SMP;
        end
        PH_I_SMP: begin
          shift_nxt = {shift_r[6:0], req.sda_in};
          phase_nxt = PH_I_LO;
        end
        PH_I_LO: begin
          scl_nxt     = 1'b0;
          bit_cnt_nxt = cnt_inc;
          phase_nxt   = (cnt_inc >= 4'd8) ? PH_I_ACKHI : PH_I_HI;
        end
        PH_I_ACKHI: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_I_ACKLO;
        end
        PH_I_ACKLO: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_I_REL2;
        end
        PH_I_REL2: begin
          sda_nxt   = i2cbdm_pkg::SDA_REL;
          phase_nxt = PH_P_CLK0;
        end
        PH_P_CLK0: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_P_DAT0;
        end
        PH_P_DAT0: begin
          sda_nxt   = i2cbdm_pkg::SDA_LOW;
          phase_nxt = PH_P_CLK1;
        end
        PH_P_CLK1: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_P_DAT1;
        end
        PH_P_DAT1: begin
          sda_nxt   = i2cbdm_pkg::SDA_HIGH;
          done      = 1'b1;
          data      = is_read_r ? shift_r : val_r;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_out     = scl_nxt;
    res.sda_drive   = sda_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.nack_error  = nack;
    res.result_data = data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= 4'd0;
      shift_r   <= 8'd0;
      is_read_r <= 1'b0;
      addr_r    <= 7'd0;
      cmd_r     <= 8'd0;
      val_r     <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= i2cbdm_pkg::SDA_REL;
      stage_r   <= i2cbdm_pkg::BS_ADDR;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      is_read_r <= is_read_nxt;
      addr_r    <= addr_nxt;
      cmd_r     <= cmd_nxt;
      val_r     <= val_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      stage_r   <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/i2cbdm_chk.sv @@
// Port checker for the I2C byte-data master and its bind to the top level.
`default_nettype none

module i2cbdm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("ending word still reports busy");

  a_nack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4] && out_tdata[13:6] == 8'd0)
    else $error("nack without done or with data");

  a_data_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13:6] != 8'd0 |-> out_tdata[4])
    else $error("result data outside an ending word");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off without a stalled result");

endmodule

bind i2c_byte_data_master_top i2cbdm_chk u_chk (.*);

`default_nettype wire

@@ test/i2c_byte_data_master_top_test.sv @@
// Self-checking testbench for the I2C byte-data master top level.
`timescale 1ns / 1ps

module i2c_byte_data_master_top_test;

  typedef enum logic [25:0] {
    SQ_IDLE       = 26'h0000001,
    SQ_ST_CLK0    = 26'h0000002,
    SQ_ST_DAT1    = 26'h0000004,
    SQ_ST_CLK1    = 26'h0000008,
    SQ_ST_DAT0    = 26'h0000010,
    SQ_TX_CLK0    = 26'h0000020,
    SQ_TX_DATA    = 26'h0000040,
    SQ_TX_HI      = 26'h0000080,
    SQ_TX_LO      = 26'h0000100,
    SQ_TX_REL     = 26'h0000200,
    SQ_TX_ACKHI   = 26'h0000400,
    SQ_TX_ACKSMP  = 26'h0000800,
    SQ_TX_ACKLO   = 26'h0001000,
    SQ_TX_ACKFAIL = 26'h0002000,
    SQ_RX_CLK0    = 26'h0004000,
    SQ_RX_REL     = 26'h0008000,
    SQ_RX_HI      = 26'h0010000,
    SQ_RX_SMP     = 26'h0020000,
    SQ_RX_LO      = 26'h0040000,
    SQ_RX_ACKHI   = 26'h0080000,
    SQ_RX_ACKLO   = 26'h0100000,
    SQ_RX_REL2    = 26'h0200000,
    SQ_SP_CLK0    = 26'h0400000,
    SQ_SP_DAT0    = 26'h0800000,
    SQ_SP_CLK1    = 26'h1000000,
    SQ_SP_DAT1    = 26'h2000000
  } seq_state_t;

  typedef enum logic [1:0] { ROW_WORD, ROW_READ, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [1:0]       mode;
    logic [6:0]       addr;
    logic [7:0]       cmd;
    logic [7:0]       val;
    logic [7:0]       rd_byte;
    int               fail_at;
    bit               noisy;
    logic             sda;
    bit               typed;
    i2cbdm_pkg::res_t want;
  } plan_row_t;

  localparam int         NO_FAIL     = -1;
  localparam int         ITEM_TARGET = 910;
  localparam logic [1:0] M_TICK      = i2cbdm_pkg::MODE_TICK;
  localparam logic [1:0] M_NONE      = i2cbdm_pkg::MODE_NONE;
  localparam i2cbdm_pkg::res_t PINS_RESET =
    '{1'b1, i2cbdm_pkg::SDA_REL, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam i2cbdm_pkg::res_t PINS_STOP =
    '{1'b1, i2cbdm_pkg::SDA_HIGH, 1'b0, 1'b0, 1'b0, 8'h00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  seq_state_t sq = SQ_IDLE;
  logic [3:0] sq_bits = '0;
  logic [7:0] sq_shift = '0;
  logic       sq_rd = 1'b0;
  logic [6:0] sq_addr = '0;
  logic [7:0] sq_cmd = '0;
  logic [7:0] sq_val = '0;
  logic       sq_scl = 1'b1;
  logic [1:0] sq_sda = i2cbdm_pkg::SDA_REL;
  logic [1:0] sq_stage = i2cbdm_pkg::BS_ADDR;

  i2cbdm_pkg::res_t pins_expected_q[$];
  plan_row_t        plan[11];
  int               fails = 0;
  int               words_seen = 0;
  int               work_items = 0;
  int               n_reads = 0;
  int               n_writes = 0;
  int               n_nacks = 0;
  int               n_ignored = 0;
  int               send_idle_pct = 25;
  int               recv_idle_pct = 63;
  bit               hold_done = 1'b0;

  i2c_byte_data_master_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic i2cbdm_pkg::res_t seq_step(input i2cbdm_pkg::req_t w);
    i2cbdm_pkg::res_t r;
    r = '0;
    if (sq == SQ_IDLE) begin
      if (w.mode == i2cbdm_pkg::MODE_READ || w.mode == i2cbdm_pkg::MODE_WRITE) begin
        sq_rd = (w.mode == i2cbdm_pkg::MODE_READ);
        sq_addr = w.target_addr;
        sq_cmd = w.command;
        sq_val = w.write_value;
        sq_stage = i2cbdm_pkg::BS_ADDR;
        sq_bits = '0;
        sq = SQ_ST_CLK0;
      end
    end else if (w.mode == i2cbdm_pkg::MODE_TICK) begin
      case (sq)
        SQ_ST_CLK0: begin sq_scl = 1'b0; sq = SQ_ST_DAT1; end
        SQ_ST_DAT1: begin sq_sda = i2cbdm_pkg::SDA_HIGH; sq = SQ_ST_CLK1; end
        SQ_ST_CLK1: begin sq_scl = 1'b1; sq = SQ_ST_DAT0; end
        SQ_ST_DAT0: begin
          sq_sda = i2cbdm_pkg::SDA_LOW;
          sq_shift = {sq_addr, sq_stage == i2cbdm_pkg::BS_DATA};
          sq_bits = '0;
          sq = SQ_TX_CLK0;
        end
        SQ_TX_CLK0: begin sq_scl = 1'b0; sq = SQ_TX_DATA; end
        SQ_TX_DATA: begin
          sq_sda = sq_shift[7] ? i2cbdm_pkg::SDA_HIGH : i2cbdm_pkg::SDA_LOW;
          sq = SQ_TX_HI;
        end
        SQ_TX_HI: begin sq_scl = 1'b1; sq = SQ_TX_LO; end
        SQ_TX_LO: begin
          sq_scl = 1'b0;
          sq_shift = sq_shift << 1;
          sq_bits = sq_bits + 4'd1;
          sq = (sq_bits >= 4'd8) ? SQ_TX_REL : SQ_TX_DATA;
        end
        SQ_TX_REL: begin sq_sda = i2cbdm_pkg::SDA_REL; sq = SQ_TX_ACKHI; end
        SQ_TX_ACKHI: begin sq_scl = 1'b1; sq = SQ_TX_ACKSMP; end
        SQ_TX_ACKSMP: sq = w.sda_in ? SQ_TX_ACKFAIL : SQ_TX_ACKLO;
        SQ_TX_ACKFAIL: begin
          sq_scl = 1'b0;
          r.done_res = 1'b1;
          r.nack_error = 1'b1;
          n_nacks++;
          sq = SQ_IDLE;
        end
        SQ_TX_ACKLO: begin
          sq_scl = 1'b0;
          sq_bits = '0;
          if (sq_stage == i2cbdm_pkg::BS_ADDR) begin
            sq_stage = i2cbdm_pkg::BS_CMD;
            sq_shift = sq_cmd;
            sq = SQ_TX_CLK0;
          end else if (sq_stage == i2cbdm_pkg::BS_CMD) begin
            sq_stage = i2cbdm_pkg::BS_DATA;
            if (sq_rd) begin
              sq = SQ_ST_CLK0;
            end else begin
              sq_shift = sq_val;
              sq = SQ_TX_CLK0;
            end
          end else begin
            sq_shift = '0;
            sq = sq_rd ? SQ_RX_CLK0 : SQ_SP_CLK0;
          end
        end
        SQ_RX_CLK0: begin sq_scl = 1'b0; sq = SQ_RX_REL; end
        SQ_RX_REL: begin sq_sda = i2cbdm_pkg::SDA_REL; sq = SQ_RX_HI; end
        SQ_RX_HI: begin sq_scl = 1'b1; sq = SQ_RX_SMP; end
        SQ_RX_SMP: begin sq_shift = {sq_shift[6:0], w.sda_in}; sq = SQ_RX_LO; end
        SQ_RX_LO: begin
          sq_scl = 1'b0;
          sq_bits = sq_bits + 4'd1;
          sq = (sq_bits >= 4'd8) ? SQ_RX_ACKHI : SQ_RX_HI;
        end
        SQ_RX_ACKHI: begin sq_scl = 1'b1; sq = SQ_RX_ACKLO; end
        SQ_RX_ACKLO: begin sq_scl = 1'b0; sq = SQ_RX_REL2; end
        SQ_RX_REL2: begin sq_sda = i2cbdm_pkg::SDA_REL; sq = SQ_SP_CLK0; end
        SQ_SP_CLK0: begin sq_scl = 1'b0; sq = SQ_SP_DAT0; end
        SQ_SP_DAT0: begin sq_sda = i2cbdm_pkg::SDA_LOW; sq = SQ_SP_CLK1; end
        SQ_SP_CLK1: begin sq_scl = 1'b1; sq = SQ_SP_DAT1; end
        SQ_SP_DAT1: begin
          sq_sda = i2cbdm_pkg::SDA_HIGH;
          r.done_res = 1'b1;
          r.result_data = sq_rd ? sq_shift : sq_val;
          sq = SQ_IDLE;
        end
        default: sq = SQ_IDLE;
      endcase
    end
    r.scl_out = sq_scl;
    r.sda_drive = sq_sda;
    r.busy_res = (sq != SQ_IDLE);
    return r;
  endfunction

  task automatic send_word(input i2cbdm_pkg::req_t w, input bit typed,
                           input i2cbdm_pkg::res_t want);
    i2cbdm_pkg::res_t e;
    bit               works;
    if (work_items + n_ignored < 320) begin
      send_idle_pct = 25;
      recv_idle_pct = 63;
    end else if (work_items + n_ignored < 640) begin
      send_idle_pct = 63;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.mode;
    in_tdata <= {w.sda_in, w.write_value, w.command, w.target_addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    works = (sq != SQ_IDLE) ? (w.mode == i2cbdm_pkg::MODE_TICK)
                            : (w.mode == i2cbdm_pkg::MODE_READ ||
                               w.mode == i2cbdm_pkg::MODE_WRITE);
    if (works) work_items++;
    else n_ignored++;
    e = seq_step(w);
    if (typed) e = want;
    pins_expected_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic run_transfer(input bit rd, input logic [6:0] a, input logic [7:0] c,
                              input logic [7:0] v, input logic [7:0] rb,
                              input int fail_at, input bit noisy);
    i2cbdm_pkg::req_t w;
    w.mode = rd ? i2cbdm_pkg::MODE_READ : i2cbdm_pkg::MODE_WRITE;
    w.target_addr = a;
    w.command = c;
    w.write_value = v;
    w.sda_in = 1'($urandom_range(1));
    if (rd) n_reads++;
    else n_writes++;
    send_word(w, 1'b0, PINS_RESET);
    while (sq != SQ_IDLE) begin
      if (noisy && $urandom_range(99) < 6) begin
        w.mode = 2'($urandom_range(1, 3));
        w.target_addr = 7'($urandom);
        w.command = 8'($urandom);
        w.write_value = 8'($urandom);
        w.sda_in = 1'($urandom_range(1));
      end else begin
        w.mode = i2cbdm_pkg::MODE_TICK;
        w.sda_in = 1'($urandom_range(1));
        if (sq == SQ_TX_ACKSMP) w.sda_in = (int'(sq_stage) == fail_at);
        else if (sq == SQ_RX_SMP) w.sda_in = rb[7 - int'(sq_bits)];
      end
      send_word(w, 1'b0, PINS_RESET);
    end
  endtask

  always @(posedge clk) begin
    i2cbdm_pkg::res_t got;
    i2cbdm_pkg::res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl_out = out_tdata[0];
      got.sda_drive = out_tdata[2:1];
      got.busy_res = out_tdata[3];
      got.done_res = out_tdata[4];
      got.nack_error = out_tdata[5];
      got.result_data = out_tdata[13:6];
      words_seen++;
      if (pins_expected_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result word %h", $time, out_tdata);
      end else begin
        e = pins_expected_q.pop_front();
        if (got.scl_out !== e.scl_out || got.sda_drive !== e.sda_drive ||
            got.busy_res !== e.busy_res || got.done_res !== e.done_res ||
            got.nack_error !== e.nack_error || got.result_data !== e.result_data) begin
          fails++;
          $display("%0t: word %0d expected scl=%b sda=%0d busy=%b done=%b nack=%b data=%h",
                   $time, words_seen, e.scl_out, e.sda_drive, e.busy_res, e.done_res,
                   e.nack_error, e.result_data);
          $display("%0t: word %0d actual   scl=%b sda=%0d busy=%b done=%b nack=%b data=%h",
                   $time, words_seen, got.scl_out, got.sda_drive, got.busy_res,
                   got.done_res, got.nack_error, got.result_data);
        end
      end
    end
  end

  // The long hold lets the result and input registers fill so that in_tready falls.
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && words_seen >= 200) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (60) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #400000;
    $display("i2c_byte_data_master_top regression: fail");
    $finish;
  end

  initial begin
    plan_row_t        row;
    i2cbdm_pkg::req_t w;
    int               r;
    int               fail_at;
    plan = '{
      '{ROW_WORD,  M_TICK, 7'h00, 8'h00, 8'h00, 8'h00, NO_FAIL, 1'b0, 1'b1, 1'b1, PINS_RESET},
      '{ROW_WORD,  M_NONE, 7'h7f, 8'hff, 8'hff, 8'h00, NO_FAIL, 1'b0, 1'b1, 1'b1, PINS_RESET},
      '{ROW_WRITE, M_TICK, 7'h7f, 8'hff, 8'h00, 8'h00, NO_FAIL, 1'b0, 1'b0, 1'b0, PINS_RESET},
      '{ROW_WORD,  M_TICK, 7'h00, 8'h00, 8'h00, 8'h00, NO_FAIL, 1'b0, 1'b0, 1'b1, PINS_STOP},
      '{ROW_READ,  M_TICK, 7'h7f, 8'h00, 8'h00, 8'hff, NO_FAIL, 1'b0, 1'b0, 1'b0, PINS_RESET},
      '{ROW_WRITE, M_TICK, 7'h2a, 8'h5a, 8'hc3, 8'h00, 0,       1'b0, 1'b0, 1'b0, PINS_RESET},
      '{ROW_WORD,  M_TICK, 7'h11, 8'h22, 8'h33, 8'h00, NO_FAIL, 1'b0, 1'b1, 1'b0, PINS_RESET},
      '{ROW_WRITE, M_TICK, 7'h15, 8'h81, 8'h7e, 8'h00, 1,       1'b0, 1'b0, 1'b0, PINS_RESET},
      '{ROW_WRITE, M_TICK, 7'h6b, 8'h33, 8'hcc, 8'h00, 2,       1'b0, 1'b0, 1'b0, PINS_RESET},
      '{ROW_READ,  M_TICK, 7'h40, 8'h10, 8'h00, 8'h96, 1,       1'b0, 1'b0, 1'b0, PINS_RESET},
      '{ROW_READ,  M_TICK, 7'h3f, 8'h99, 8'h00, 8'h69, 2,       1'b0, 1'b0, 1'b0, PINS_RESET}
    };
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WORD) begin
        w.mode = row.mode;
        w.target_addr = row.addr;
        w.command = row.cmd;
        w.write_value = row.val;
        w.sda_in = row.sda;
        send_word(w, row.typed, row.want);
      end else begin
        run_transfer(row.kind == ROW_READ, row.addr, row.cmd, row.val, row.rd_byte,
                     row.fail_at, row.noisy);
      end
    end

    while (work_items + n_ignored < ITEM_TARGET) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 2)) begin
          w.mode = ($urandom_range(1) != 0) ? i2cbdm_pkg::MODE_TICK : i2cbdm_pkg::MODE_NONE;
          w.target_addr = 7'($urandom);
          w.command = 8'($urandom);
          w.write_value = 8'($urandom);
          w.sda_in = 1'($urandom_range(1));
          send_word(w, 1'b0, PINS_RESET);
        end
      end
      r = $urandom_range(99);
      fail_at = (r < 20) ? $urandom_range(2) : NO_FAIL;
      run_transfer($urandom_range(1) != 0, 7'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), fail_at, $urandom_range(99) < 30);
    end
    in_tvalid <= 1'b0;

    while (pins_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d reads and %0d writes, %0d of them ending on a missing acknowledge.",
             n_reads, n_writes, n_nacks);
    $display("Words checked: %0d, of which %0d had no effect on the sequencer.",
             words_seen, n_ignored);
    if (fails == 0 && pins_expected_q.size() == 0) begin
      $display("i2c_byte_data_master_top regression: pass");
    end else begin
      $display("i2c_byte_data_master_top regression: fail");
    end
    $finish;
  end

endmodule
